/* design/rte_pkg.sv */
// Shared types, constants and CORDIC step functions for rotation_to_euler_angles.
// No dependencies; every other design file imports this package.
package rte_pkg;

   localparam int CORDIC_STAGES = 16;   // micro-rotations per CORDIC, 8..24
   localparam int VAL_W         = 32;   // datapath width, Q.22 entries and Q.24 angles
   localparam int ENTRY_W       = 16;
   localparam int ENTRY_SHIFT   = 8;    // Q2.14 -> Q.22
   localparam int PROD_W        = 48;
   localparam int GAIN_Q16      = 107922;
   localparam int GAIN_SHIFT    = 16;
   localparam int PI_Q13        = 25736;
   localparam int TWO_PI_Q13    = 51472;
   localparam int ROUND_BIAS    = 1024;
   localparam int OUT_SHIFT     = 11;

   typedef logic signed [VAL_W-1:0]   val_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;

   localparam val_type HALF_PI_Q24 = 32'sd26353589;
   localparam val_type ATAN_LOW [8] = '{32'sd13176795, 32'sd7778716, 32'sd4110060,
                                        32'sd2086331, 32'sd1047214, 32'sd524117,
                                        32'sd262123, 32'sd131069};

   typedef struct packed {
      logic    zero;
      val_type x;
      val_type y;
      val_type z;
   } vec_type;

   typedef struct packed {
      val_type a;
      val_type b;
   } pair_type;

   function automatic val_type atan_step(input int i);
      val_type r;
      if (i < 8) begin
         r = ATAN_LOW[i[2:0]];
      end else if (i <= 24) begin
         r = val_type'(32'sd1 <<< (24 - i));
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // Zero check and quadrant pre-rotation into the right half plane.
   function automatic vec_type vec_init(input val_type x, input val_type y);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.x    = x;
      v.y    = y;
      v.z    = '0;
      if (x[VAL_W-1]) begin
         if (!y[VAL_W-1]) begin
            v.x = y;
            v.y = -x;
            v.z = HALF_PI_Q24;
         end else begin
            v.x = -y;
            v.y = x;
            v.z = -HALF_PI_Q24;
         end
      end
      return v;
   endfunction

   function automatic pair_type pair_init(input pair_type p, input val_type x,
                                          input val_type y);
      pair_type q;
      q = p;
      if (x[VAL_W-1]) begin
         if (!y[VAL_W-1]) begin
            q.a = p.b;
            q.b = -p.a;
         end else begin
            q.a = -p.b;
            q.b = p.a;
         end
      end
      return q;
   endfunction

   function automatic vec_type vec_step(input vec_type v, input int i);
      vec_type r;
      logic    up;
      r  = v;
      up = !v.y[VAL_W-1];
      if (!v.zero) begin
         r.x = up ? v.x + (v.y >>> i) : v.x - (v.y >>> i);
         r.y = up ? v.y - (v.x >>> i) : v.y + (v.x >>> i);
         r.z = up ? v.z + atan_step(i) : v.z - atan_step(i);
      end
      return r;
   endfunction

   function automatic pair_type pair_step(input pair_type p, input vec_type v,
                                          input int i);
      pair_type r;
      logic     up;
      r  = p;
      up = !v.y[VAL_W-1];
      if (!v.zero) begin
         r.a = up ? p.a + (p.b >>> i) : p.a - (p.b >>> i);
         r.b = up ? p.b - (p.a >>> i) : p.b + (p.a >>> i);
      end
      return r;
   endfunction

   // Q.24 -> Q.13 with rounding, wrap into [-pi, pi) and clamp.
   function automatic entry_type to_output(input val_type z);
      val_type a;
      a = (z + val_type'(ROUND_BIAS)) >>> OUT_SHIFT;
      if (a >= val_type'(PI_Q13)) begin
         a = a - val_type'(TWO_PI_Q13);
      end else if (a < -val_type'(PI_Q13)) begin
         a = a + val_type'(TWO_PI_Q13);
      end
      if (a > val_type'(PI_Q13 - 1)) begin
         a = val_type'(PI_Q13 - 1);
      end
      if (a < -val_type'(PI_Q13)) begin
         a = -val_type'(PI_Q13);
      end
      return entry_type'(a);
   endfunction

endpackage

/* design/rte_yaw_pipe.sv */
// Yaw CORDIC pipeline: input register, scaling and pre-rotation, then one
// register stage per micro-rotation. Column companions ride along. Uses rte_pkg.
module rte_yaw_pipe import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      ce,
   input  logic      in_valid,
   input  entry_type in_r00,
   input  entry_type in_r10,
   input  entry_type in_r20,
   input  entry_type in_r01,
   input  entry_type in_r11,
   input  entry_type in_r02,
   input  entry_type in_r12,
   output logic      out_valid,
   output vec_type   out_vec,
   output pair_type  out_col1,
   output pair_type  out_col2,
   output val_type   out_pitch_y
);

   logic      a_v_ff;
   entry_type a_r00_ff, a_r10_ff, a_r20_ff, a_r01_ff, a_r11_ff, a_r02_ff, a_r12_ff;

   logic      v_ff   [CORDIC_STAGES+1];
   vec_type   vec_ff [CORDIC_STAGES+1];
   pair_type  c1_ff  [CORDIC_STAGES+1];
   pair_type  c2_ff  [CORDIC_STAGES+1];
   val_type   py_ff  [CORDIC_STAGES+1];

   val_type              r00_s, r10_s, r20_neg;
   pair_type             c1_raw, c2_raw;
   logic signed [PROD_W-1:0] py_prod;
   vec_type              vec_in;
   pair_type             c1_in, c2_in;
   val_type              py_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (ce) begin
         a_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_r00_ff <= in_r00;
         a_r10_ff <= in_r10;
         a_r20_ff <= in_r20;
         a_r01_ff <= in_r01;
         a_r11_ff <= in_r11;
         a_r02_ff <= in_r02;
         a_r12_ff <= in_r12;
      end
   end

   // Q.22 scaling, gain-corrected pitch numerator, quadrant pre-rotation
   always_comb begin
      r00_s    = val_type'(a_r00_ff) <<< ENTRY_SHIFT;
      r10_s    = val_type'(a_r10_ff) <<< ENTRY_SHIFT;
      r20_neg  = -(val_type'(a_r20_ff) <<< ENTRY_SHIFT);
      c1_raw.a = val_type'(a_r01_ff) <<< ENTRY_SHIFT;
      c1_raw.b = val_type'(a_r11_ff) <<< ENTRY_SHIFT;
      c2_raw.a = val_type'(a_r02_ff) <<< ENTRY_SHIFT;
      c2_raw.b = val_type'(a_r12_ff) <<< ENTRY_SHIFT;
      py_prod  = PROD_W'(r20_neg) * PROD_W'(GAIN_Q16);
      py_in    = val_type'(py_prod >>> GAIN_SHIFT);
      vec_in   = vec_init(r00_s, r10_s);
      c1_in    = pair_init(c1_raw, r00_s, r10_s);
      c2_in    = pair_init(c2_raw, r00_s, r10_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         vec_ff[0] <= vec_in;
         c1_ff[0]  <= c1_in;
         c2_ff[0]  <= c2_in;
         py_ff[0]  <= py_in;
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ce) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            vec_ff[k+1] <= vec_step(vec_ff[k], k);
            c1_ff[k+1]  <= pair_step(c1_ff[k], vec_ff[k], k);
            c2_ff[k+1]  <= pair_step(c2_ff[k], vec_ff[k], k);
            py_ff[k+1]  <= py_ff[k];
         end
      end
   end

   assign out_valid   = v_ff[CORDIC_STAGES];
   assign out_vec     = vec_ff[CORDIC_STAGES];
   assign out_col1    = c1_ff[CORDIC_STAGES];
   assign out_col2    = c2_ff[CORDIC_STAGES];
   assign out_pitch_y = py_ff[CORDIC_STAGES];

endmodule

/* design/rte_pr_pipe.sv */
// Pitch and roll CORDIC pipelines side by side, fed from the yaw result;
// the yaw angle is delayed alongside. Uses rte_pkg.
module rte_pr_pipe import rte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     ce,
   input  logic     in_valid,
   input  vec_type  in_yaw,
   input  pair_type in_col1,
   input  pair_type in_col2,
   input  val_type  in_pitch_y,
   output logic     out_valid,
   output val_type  out_yaw_z,
   output val_type  out_pitch_z,
   output val_type  out_roll_z
);

   logic    v_ff     [CORDIC_STAGES+1];
   vec_type pitch_ff [CORDIC_STAGES+1];
   vec_type roll_ff  [CORDIC_STAGES+1];
   val_type yaw_ff   [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (ce) begin
         v_ff[0] <= in_valid;
      end
   end

   // roll = atan2(-b of third column, b of second column)
   always_ff @(posedge clock) begin
      if (ce) begin
         pitch_ff[0] <= vec_init(in_yaw.x, in_pitch_y);
         roll_ff[0]  <= vec_init(in_col1.b, -in_col2.b);
         yaw_ff[0]   <= in_yaw.zero ? '0 : in_yaw.z;
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (ce) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            pitch_ff[k+1] <= vec_step(pitch_ff[k], k);
            roll_ff[k+1]  <= vec_step(roll_ff[k], k);
            yaw_ff[k+1]   <= yaw_ff[k];
         end
      end
   end

   assign out_valid   = v_ff[CORDIC_STAGES];
   assign out_yaw_z   = yaw_ff[CORDIC_STAGES];
   assign out_pitch_z = pitch_ff[CORDIC_STAGES].zero ? '0 : pitch_ff[CORDIC_STAGES].z;
   assign out_roll_z  = roll_ff[CORDIC_STAGES].zero ? '0 : roll_ff[CORDIC_STAGES].z;

endmodule

/* design/rte_out_buf.sv */
// Angle rounding/wrap and two-entry output buffer (output register plus skid).
// Produces the pipeline enable. Uses rte_pkg.
module rte_out_buf import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  val_type   in_yaw_z,
   input  val_type   in_pitch_z,
   input  val_type   in_roll_z,
   output logic      ce,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output entry_type rsp_yaw_angle,
   output entry_type rsp_pitch_angle,
   output entry_type rsp_roll_angle
);

   logic      out_v_ff, skid_v_ff;
   entry_type out_y_ff, out_p_ff, out_r_ff;
   entry_type skid_y_ff, skid_p_ff, skid_r_ff;
   entry_type new_y, new_p, new_r;
   logic      arrive, pop;

   assign ce     = !skid_v_ff;
   assign arrive = ce && in_valid;
   assign pop    = out_v_ff && !rsp_stall;
   assign new_y  = to_output(in_yaw_z);
   assign new_p  = to_output(in_pitch_z);
   assign new_r  = to_output(in_roll_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_y_ff <= skid_y_ff;
            out_p_ff <= skid_p_ff;
            out_r_ff <= skid_r_ff;
         end
      end else if (arrive) begin
         if (out_v_ff && !pop) begin
            skid_y_ff <= new_y;
            skid_p_ff <= new_p;
            skid_r_ff <= new_r;
         end else begin
            out_y_ff <= new_y;
            out_p_ff <= new_p;
            out_r_ff <= new_r;
         end
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_yaw_angle   = out_y_ff;
   assign rsp_pitch_angle = out_p_ff;
   assign rsp_roll_angle  = out_r_ff;

endmodule

/* design/rotation_to_euler_angles.sv */
// Top level: rotation matrix (Q2.14) to yaw, pitch, roll (Q3.13 radians).
// Depends on rte_pkg, rte_yaw_pipe, rte_pr_pipe and rte_out_buf.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | seven matrix entries, 16 bit signed
//  rsp     | out       | rsp_valid/rsp_stall | yaw, pitch, roll angles, 16 bit signed
//
// One transfer can be taken every cycle while req_stall is low. Data passes
// through the input register, yaw pre-rotation, the yaw micro-rotations,
// pitch/roll pre-rotation, the pitch/roll micro-rotations, output register.
// Reset (synchronous) clears only the valid bits, which empties the output buffer.
// A skid entry behind the output register lets one more transfer drain while
// rsp is stalled; req_stall is the registered skid-full flag, so the whole
// pipe freezes together and nothing is dropped or repeated.
module rotation_to_euler_angles import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  entry_type req_row0_col0,
   input  entry_type req_row1_col0,
   input  entry_type req_row2_col0,
   input  entry_type req_row0_col1,
   input  entry_type req_row1_col1,
   input  entry_type req_row0_col2,
   input  entry_type req_row1_col2,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output entry_type rsp_yaw_angle,
   output entry_type rsp_pitch_angle,
   output entry_type rsp_roll_angle
);

   logic     ce;
   logic     yaw_valid;
   vec_type  yaw_vec;
   pair_type yaw_col1, yaw_col2;
   val_type  yaw_pitch_y;
   logic     pr_valid;
   val_type  pr_yaw_z, pr_pitch_z, pr_roll_z;

   assign req_stall = !ce;

   // yaw = atan2(r10, r00); both other columns are turned by -yaw alongside
   rte_yaw_pipe u_yaw (
      .clock       (clock),
      .reset       (reset),
      .ce          (ce),
      .in_valid    (req_valid),
      .in_r00      (req_row0_col0),
      .in_r10      (req_row1_col0),
      .in_r20      (req_row2_col0),
      .in_r01      (req_row0_col1),
      .in_r11      (req_row1_col1),
      .in_r02      (req_row0_col2),
      .in_r12      (req_row1_col2),
      .out_valid   (yaw_valid),
      .out_vec     (yaw_vec),
      .out_col1    (yaw_col1),
      .out_col2    (yaw_col2),
      .out_pitch_y (yaw_pitch_y)
   );

   // pitch uses the gain-grown magnitude from the yaw CORDIC as its x
   rte_pr_pipe u_pr (
      .clock       (clock),
      .reset       (reset),
      .ce          (ce),
      .in_valid    (yaw_valid),
      .in_yaw      (yaw_vec),
      .in_col1     (yaw_col1),
      .in_col2     (yaw_col2),
      .in_pitch_y  (yaw_pitch_y),
      .out_valid   (pr_valid),
      .out_yaw_z   (pr_yaw_z),
      .out_pitch_z (pr_pitch_z),
      .out_roll_z  (pr_roll_z)
   );

   rte_out_buf u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pr_valid),
      .in_yaw_z        (pr_yaw_z),
      .in_pitch_z      (pr_pitch_z),
      .in_roll_z       (pr_roll_z),
      .ce              (ce),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_roll_angle  (rsp_roll_angle)
   );

endmodule

/* tb/rte_checker.sv */
// Scoreboard for rotation_to_euler_angles: predicts yaw/pitch/roll per request
// transfer and compares each response transfer in order. Depends on rte_pkg.
module rte_checker import rte_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_stall,
   input  entry_type req_row0_col0,
   input  entry_type req_row1_col0,
   input  entry_type req_row2_col0,
   input  entry_type req_row0_col1,
   input  entry_type req_row1_col1,
   input  entry_type req_row0_col2,
   input  entry_type req_row1_col2,
   input  logic      rsp_valid,
   input  logic      rsp_stall,
   input  entry_type rsp_yaw_angle,
   input  entry_type rsp_pitch_angle,
   input  entry_type rsp_roll_angle,
   output int        fail_count,
   output int        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      entry_type yaw;
      entry_type pitch;
      entry_type roll;
   } euler_type;

   localparam longint ARC_TAB [8] = '{13176795, 7778716, 4110060, 2086331,
                                      1047214, 524117, 262123, 131069};
   localparam longint QUARTER_TURN = 26353589;

   euler_type angles_due[$];

   initial fail_count = 0;
   assign pending = angles_due.size();

   function automatic longint arc_of(input int i);
      if (i < 8) return ARC_TAB[i];
      if (i <= 24) return longint'(1) <<< (24 - i);
      return 0;
   endfunction

   // vectoring rotation; companions in cols[0..2*npairs-1] follow it
   function automatic longint vector_angle(inout longint x, inout longint y,
                                           inout longint cols [4], input int npairs);
      longint z, t, dx, dy, a, b;
      logic   up;
      int     n;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
            for (int k = 0; k < npairs; k++) begin
               t = cols[2*k]; cols[2*k] = cols[2*k+1]; cols[2*k+1] = -t;
            end
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
            for (int k = 0; k < npairs; k++) begin
               t = cols[2*k]; cols[2*k] = -cols[2*k+1]; cols[2*k+1] = t;
            end
         end
      end
      n = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
      for (int i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         up = (y >= 0);
         x = up ? x + dx : x - dx;
         y = up ? y - dy : y + dy;
         z = up ? z + arc_of(i) : z - arc_of(i);
         for (int k = 0; k < npairs; k++) begin
            a = cols[2*k];
            b = cols[2*k+1];
            cols[2*k]   = up ? a + (b >>> i) : a - (b >>> i);
            cols[2*k+1] = up ? b - (a >>> i) : b + (a >>> i);
         end
      end
      return z;
   endfunction

   function automatic entry_type wrap_angle(input longint z);
      longint a;
      a = (z + 1024) >>> 11;
      if (a >= PI_Q13) a -= TWO_PI_Q13;
      else if (a < -PI_Q13) a += TWO_PI_Q13;
      if (a > PI_Q13 - 1) a = PI_Q13 - 1;
      if (a < -PI_Q13) a = -PI_Q13;
      return entry_type'(a);
   endfunction

   function automatic euler_type predict_euler();
      longint    cols [4];
      longint    x, y, zy, zp, zr;
      euler_type e;
      cols[0] = longint'(req_row0_col1) * 256;
      cols[1] = longint'(req_row1_col1) * 256;
      cols[2] = longint'(req_row0_col2) * 256;
      cols[3] = longint'(req_row1_col2) * 256;
      x  = longint'(req_row0_col0) * 256;
      y  = longint'(req_row1_col0) * 256;
      zy = vector_angle(x, y, cols, 2);
      y  = (-(longint'(req_row2_col0) * 256) * GAIN_Q16) >>> 16;
      zp = vector_angle(x, y, cols, 0);
      x  = cols[1];
      y  = -cols[3];
      zr = vector_angle(x, y, cols, 0);
      e.yaw   = wrap_angle(zy);
      e.pitch = wrap_angle(zp);
      e.roll  = wrap_angle(zr);
      return e;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      euler_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (angles_due.size() == 0) begin
               report("unexpected transfer, yaw", rsp_yaw_angle, 0);
            end else begin
               e = angles_due.pop_front();
               if (rsp_yaw_angle !== e.yaw) report("yaw", rsp_yaw_angle, e.yaw);
               if (rsp_pitch_angle !== e.pitch) report("pitch", rsp_pitch_angle, e.pitch);
               if (rsp_roll_angle !== e.roll) report("roll", rsp_roll_angle, e.roll);
            end
         end
         if (req_valid && !req_stall) angles_due.push_back(predict_euler());
      end
   end
endmodule

/* tb/rotation_to_euler_angles_tb.sv */
// Top of the rotation_to_euler_angles testbench: clock, reset, stimulus, verdict.
// Depends on rte_pkg, rte_checker and the design under test.
module rotation_to_euler_angles_tb;
   import rte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1830;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * CORDIC_STAGES + 20;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   entry_type req_row0_col0 = '0, req_row1_col0 = '0, req_row2_col0 = '0;
   entry_type req_row0_col1 = '0, req_row1_col1 = '0;
   entry_type req_row0_col2 = '0, req_row1_col2 = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   entry_type rsp_yaw_angle, rsp_pitch_angle, rsp_roll_angle;
   int        fail_count, pending;

   // quiet: no random idling on either side; hold_req: receiver holds off
   bit        quiet = 1'b0;
   bit        hold_req = 1'b0;
   int        cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rotation_to_euler_angles dut (.*);

   rte_checker checker_i (.*);

   // cycle budget; a hung pipe ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("rotation_to_euler_angles regression: fail");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off on request so the pipe fills
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = 300;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 7);
         end
      end
   end

   // one request transfer; valid stays high into the next item unless idling
   task automatic send_matrix(input entry_type r00, r10, r20, r01, r11, r02, r12);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_row0_col0 <= r00;
      req_row1_col0 <= r10;
      req_row2_col0 <= r20;
      req_row0_col1 <= r01;
      req_row1_col1 <= r11;
      req_row0_col2 <= r02;
      req_row1_col2 <= r12;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic entry_type to_q14(input real v);
      real s;
      s = v * 16384.0;
      if (s > 32767.0) s = 32767.0;
      if (s < -32768.0) s = -32768.0;
      return entry_type'($rtoi(s < 0.0 ? s - 0.5 : s + 0.5));
   endfunction

   // proper rotation Rz(yaw) Ry(pitch) Rx(roll) with random angles
   task automatic send_rotation();
      real y, p, r, cy, sy, cp, sp, cr, sr;
      y  = ($urandom_range(65535) / 65535.0 - 0.5) * 6.2831853;
      p  = ($urandom_range(65535) / 65535.0 - 0.5) * 3.1415926;
      r  = ($urandom_range(65535) / 65535.0 - 0.5) * 6.2831853;
      cy = $cos(y); sy = $sin(y);
      cp = $cos(p); sp = $sin(p);
      cr = $cos(r); sr = $sin(r);
      send_matrix(to_q14(cy*cp), to_q14(sy*cp), to_q14(-sp),
                  to_q14(cy*sp*sr - sy*cr), to_q14(sy*sp*sr + cy*cr),
                  to_q14(cy*sp*cr + sy*sr), to_q14(sy*sp*cr - cy*sr));
   endtask

   task automatic send_noise();
      send_matrix(entry_type'($urandom), entry_type'($urandom), entry_type'($urandom),
                  entry_type'($urandom), entry_type'($urandom), entry_type'($urandom),
                  entry_type'($urandom));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identity first two columns, all zero, extremes, every quadrant, yaw of exactly pi
      send_matrix(16384, 0, 0, 0, 16384, 0, 16384);
      send_matrix(0, 0, 0, 0, 0, 0, 0);
      send_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_matrix(-32768, 0, 32767, -32768, 32767, -32768, 32767);
      send_matrix(-16384, 0, 0, 0, -16384, 0, 16384);
      send_matrix(-16384, 1, 0, 0, -16384, 0, 16384);
      send_matrix(-16384, -1, 0, 0, -16384, 0, 16384);
      send_matrix(-11585, 11585, 0, -11585, -11585, 0, 0);
      send_matrix(-11585, -11585, 0, 11585, -11585, 0, 0);
      send_matrix(0, 16384, 0, -16384, 0, 0, 0);
      send_matrix(0, -16384, 0, 16384, 0, 0, 0);
      send_matrix(0, 0, -16384, 0, 16384, 16384, 0);
      send_matrix(0, 0, 16384, 0, 16384, -16384, 0);
      send_matrix(0, 0, 0, 0, -16384, 0, 0);
      send_matrix(16384, 0, 0, 0, 0, 0, 0);
      send_matrix(32767, -32768, -32768, 32767, -32768, 32767, -32768);
      send_matrix(1, -1, 1, -1, 1, -1, 1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) begin
            // long hold-off with the sender still offering
            hold_req = 1'b1;
         end
         if (n == 700) begin
            // sender waits for the pipe to empty
            @(negedge clock);
            req_valid <= 1'b0;
            wait (pending == 0);
         end
         quiet = (n >= 900 && n < 1200);
         if ($urandom_range(99) < 75) send_rotation();
         else send_noise();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("rotation_to_euler_angles regression: pass");
      end else begin
         $display("rotation_to_euler_angles regression: fail");
      end
      $finish;
   end
endmodule
